>>> hdl/assert_macros.svh
// Assertion macros used by the checker file of this project.
// Needs a clock named clk_i and an active-low reset named rst_ni in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every rising edge outside reset.
`define LAP_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("laplacian filter check failed");

// The expression must never be true at a rising edge outside reset.
`define LAP_ASSERT_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error("laplacian filter forbidden condition seen");

`endif

>>> hdl/lap_pkg.sv
// Shared types, constants and filter functions of the Laplacian high-pass block.
// Used by every module of the block but lap_ram; depends on nothing else.
package lap_pkg;

  // Field and register widths.
  localparam int unsigned PixW     = 8;
  localparam int unsigned CfgDataW = 10;
  localparam int unsigned CfgAddrW = 1;

  // Register reset values and legal ranges.
  localparam int unsigned RstFrameWidth  = 352;
  localparam int unsigned RstFrameHeight = 288;
  localparam int unsigned MinWidth       = 3;
  localparam int unsigned MinHeight      = 2;
  localparam int unsigned MaxWidthDef    = 512;
  localparam int unsigned MaxHeightDef   = 512;

  // Arithmetic constants of the filter.
  localparam int unsigned PixOffset = 127;
  localparam int unsigned PixMax    = 255;

  // Result queue depth (power of two).
  localparam int unsigned OutqDepth = 8;

  // Configuration register indexes.
  typedef enum logic [CfgAddrW-1:0] {
    CFG_FRAME_WIDTH  = 1'b0,
    CFG_FRAME_HEIGHT = 1'b1
  } lap_cfg_idx_e;

  // Input request and result payloads.
  typedef struct packed {
    logic            mode;
    logic [PixW-1:0] pixel;
  } lap_in_t;

  typedef struct packed {
    logic [PixW-1:0] filtered;
    logic            frame_end;
  } lap_out_t;

  // 3x3 window: index row*3+col, row 0 on top, col 2 the newest column.
  typedef logic [8:0][PixW-1:0] lap_win_t;

  // Control and data of one request as it moves down the pipeline.
  typedef struct packed {
    logic            valid;
    logic [PixW-1:0] bot_pix;
    logic            clear;
    logic            use_mid;
    logic            use_top;
    logic            emit_first;
    logic            emit_last;
    logic            frame_end;
    logic            wr_en;
  } lap_stage_t;

  // Shift a new column into the window from the right.
  function automatic lap_win_t lap_shift(lap_win_t w, logic [PixW-1:0] top,
                                         logic [PixW-1:0] mid, logic [PixW-1:0] bot);
    lap_win_t r;
    r    = w;
    r[0] = w[1];
    r[1] = w[2];
    r[2] = top;
    r[3] = w[4];
    r[4] = w[5];
    r[5] = mid;
    r[6] = w[7];
    r[7] = w[8];
    r[8] = bot;
    return r;
  endfunction

  // Eight times the centre minus the neighbours, offset and clamped to a pixel.
  function automatic logic [PixW-1:0] lap_filter(lap_win_t w);
    logic signed [12:0] acc;
    acc = $signed(13'(PixOffset)) + $signed({2'b00, w[4], 3'b000});
    for (int k = 0; k < 9; k++) begin
      if (k != 4) begin
        acc = acc - $signed({5'b00000, w[k]});
      end
    end
    if (acc < 13'sd0) begin
      return '0;
    end else if (acc > $signed(13'(PixMax))) begin
      return PixW'(PixMax);
    end else begin
      return acc[PixW-1:0];
    end
  endfunction

endpackage

>>> hdl/lap_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Stand-alone; no package needed.
module lap_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/lap_front.sv
// Front stage: row and column counters, frame phase, line store read request.
// Depends on lap_pkg.
module lap_front #(
  parameter int unsigned MaxWidth  = lap_pkg::MaxWidthDef,
  parameter int unsigned MaxHeight = lap_pkg::MaxHeightDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          accept_i,
  input  lap_pkg::lap_in_t              in_data_i,
  input  logic [lap_pkg::CfgDataW-1:0]  frame_width_i,
  input  logic [lap_pkg::CfgDataW-1:0]  frame_height_i,
  output logic                          rd_en_o,
  output logic [$clog2(MaxWidth)-1:0]   rd_addr_o,
  output logic [$clog2(MaxWidth)-1:0]   wr_addr_o,
  output lap_pkg::lap_stage_t           stage_o,
  output logic [1:0]                    pend_o
);

  localparam int unsigned AW = $clog2(MaxWidth);
  localparam int unsigned RW = $clog2(MaxHeight + 1);

  logic [AW-1:0] col_q, col_d;
  logic [RW-1:0] row_q, row_d;
  logic [AW-1:0] last_col;
  logic [RW-1:0] height_eff;
  logic [31:0]   width_raw, height_raw;
  logic          flush, match, row_end, take;
  lap_pkg::lap_stage_t stage_q, stage_d;
  logic [AW-1:0] wr_addr_q;

  // Clamp the frame size registers to the supported range.
  assign width_raw  = 32'(frame_width_i);
  assign height_raw = 32'(frame_height_i);

  always_comb begin
    if (width_raw < 32'(lap_pkg::MinWidth)) begin
      last_col = AW'(lap_pkg::MinWidth - 1);
    end else if (width_raw > 32'(MaxWidth)) begin
      last_col = AW'(MaxWidth - 1);
    end else begin
      last_col = AW'(width_raw - 32'd1);
    end
    if (height_raw < 32'(lap_pkg::MinHeight)) begin
      height_eff = RW'(lap_pkg::MinHeight);
    end else if (height_raw > 32'(MaxHeight)) begin
      height_eff = RW'(MaxHeight);
    end else begin
      height_eff = RW'(height_raw);
    end
  end

  // A request whose mode does not suit the phase is dropped without effect.
  assign flush   = (row_q >= height_eff);
  assign match   = (in_data_i.mode == flush);
  assign row_end = (col_q >= last_col);
  assign take    = accept_i && match;

  // Counter update.
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (take) begin
      if (row_end) begin
        col_d = '0;
        row_d = flush ? '0 : row_q + RW'(1);
      end else begin
        col_d = col_q + AW'(1);
      end
    end
  end

  // Stage register contents for the window stage.
  always_comb begin
    stage_d.valid      = take;
    stage_d.bot_pix    = flush ? '0 : in_data_i.pixel;
    stage_d.clear      = (col_q == '0);
    stage_d.use_mid    = (row_q != '0);
    stage_d.use_top    = (row_q >= RW'(2));
    stage_d.emit_first = (row_q != '0) && (col_q != '0);
    stage_d.emit_last  = row_end && (row_q != '0);
    stage_d.frame_end  = flush;
    stage_d.wr_en      = !flush;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      row_q   <= '0;
      stage_q <= '0;
    end else begin
      col_q   <= col_d;
      row_q   <= row_d;
      stage_q <= stage_d;
    end
  end

  // Column address follows the request to the write-back stage.
  always_ff @(posedge clk_i) begin
    wr_addr_q <= col_q;
  end

  assign rd_en_o   = take;
  assign rd_addr_o = col_q;
  assign wr_addr_o = wr_addr_q;
  assign stage_o   = stage_q;
  assign pend_o    = stage_q.valid ?
                     (2'(stage_q.emit_first) + 2'(stage_q.emit_last)) : 2'd0;

endmodule

>>> hdl/lap_core.sv
// Window stage and filter stage: builds the 3x3 window, writes the line stores
// back and forms up to two results per request. Depends on lap_pkg.
module lap_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  lap_pkg::lap_stage_t           stage_i,
  input  logic [lap_pkg::PixW-1:0]      rd_above_i,
  input  logic [lap_pkg::PixW-1:0]      rd_two_above_i,
  output logic                          wr_en_o,
  output logic [lap_pkg::PixW-1:0]      wr_above_o,
  output logic [lap_pkg::PixW-1:0]      wr_two_above_o,
  output logic [1:0]                    pend_o,
  output logic [1:0]                    push_n_o,
  output lap_pkg::lap_out_t             push0_o,
  output lap_pkg::lap_out_t             push1_o
);

  lap_pkg::lap_win_t   win_q, win_d, win_base, win_tail;
  lap_pkg::lap_stage_t st2_q;
  logic [lap_pkg::PixW-1:0] top_pix, mid_pix, res_first, res_last;

  // Rows above the frame read as zero.
  assign top_pix = stage_i.use_top ? rd_two_above_i : '0;
  assign mid_pix = stage_i.use_mid ? rd_above_i : '0;

  // The window restarts from zero at the first column of a row.
  assign win_base = stage_i.clear ? '0 : win_q;
  assign win_d    = lap_pkg::lap_shift(win_base, top_pix, mid_pix, stage_i.bot_pix);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0;
      st2_q <= '0;
    end else begin
      if (stage_i.valid) begin
        win_q <= win_d;
      end
      st2_q <= stage_i;
    end
  end

  // Line store write-back: the row above moves down, the new pixel goes in.
  assign wr_en_o        = stage_i.valid && stage_i.wr_en;
  assign wr_above_o     = stage_i.bot_pix;
  assign wr_two_above_o = rd_above_i;

  // The last column also sees a zero column on its right.
  assign win_tail  = lap_pkg::lap_shift(win_q, '0, '0, '0);
  assign res_first = lap_pkg::lap_filter(win_q);
  assign res_last  = lap_pkg::lap_filter(win_tail);

  // Pack the results of this request in order.
  always_comb begin
    push_n_o = st2_q.valid ? (2'(st2_q.emit_first) + 2'(st2_q.emit_last)) : 2'd0;
    if (st2_q.emit_first) begin
      push0_o.filtered  = res_first;
      push0_o.frame_end = 1'b0;
    end else begin
      push0_o.filtered  = res_last;
      push0_o.frame_end = st2_q.frame_end;
    end
    push1_o.filtered  = res_last;
    push1_o.frame_end = st2_q.frame_end;
  end

  assign pend_o = push_n_o;

endmodule

>>> hdl/lap_outq.sv
// Result queue: takes up to two results per cycle, gives one per cycle on
// out_ready_i, tells the input side if there is room. Depends on lap_pkg.
module lap_outq (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [1:0]        push_n_i,
  input  lap_pkg::lap_out_t push0_i,
  input  lap_pkg::lap_out_t push1_i,
  input  logic [2:0]        pend_i,
  output logic              room_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output lap_pkg::lap_out_t out_data_o
);

  localparam int unsigned Depth = lap_pkg::OutqDepth;
  localparam int unsigned PW    = $clog2(Depth);
  localparam int unsigned CW    = $clog2(Depth + 1);
  localparam int unsigned SW    = CW + 1;

  lap_pkg::lap_out_t mem_q [Depth];
  logic [PW-1:0] wr_ptr_q, wr_ptr_d, wr_ptr_p1, rd_ptr_q, rd_ptr_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [SW-1:0] need;
  logic          pop;

  assign pop       = out_valid_o && out_ready_i;
  assign wr_ptr_p1 = wr_ptr_q + PW'(1);

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q + PW'(push_n_i);
    rd_ptr_d = pop ? rd_ptr_q + PW'(1) : rd_ptr_q;
    cnt_d    = cnt_q + CW'(push_n_i) - CW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_n_i != 2'd0) begin
      mem_q[wr_ptr_q] <= push0_i;
    end
    if (push_n_i == 2'd2) begin
      mem_q[wr_ptr_p1] <= push1_i;
    end
  end

  // A new request may bring two results on top of those still in flight.
  assign need   = SW'(cnt_q) + SW'(pend_i) + SW'(2);
  assign room_o = (need <= SW'(Depth));

  assign out_valid_o = (cnt_q != '0);
  assign out_data_o  = mem_q[rd_ptr_q];

endmodule

>>> hdl/laplacian_3x3_highpass_top.sv
// Streaming 3x3 Laplacian high-pass filter for 8-bit luma pixels.
// Input channel (in_valid_i/in_ready_o/in_data_i): one request per pixel in
// raster order with mode 0; after the last pixel of a frame, one row of
// flush requests with mode 1 brings out the bottom row. A request whose mode
// does not suit the current phase is dropped and gives no result.
// Output channel (out_valid_o/out_ready_i/out_data_o): the result for column
// c-1 follows the request of column c; the last column of a row gives two
// results. frame_end marks the final result of a frame.
// Configuration channel: index 0 frame width, index 1 frame height; write
// only while no request is in flight. Values outside the range are clamped.
// Throughput is one request per cycle while in_ready_o is high. A result is
// offered after the registered line store read, the window register, and the
// filter and the result queue.
// An eight-entry result queue absorbs stalls; in_ready_o falls only when the
// queue plus results in flight could overflow it.
// Reset returns the counters to the start of a frame, the size registers to
// 352 by 288 and empties the queue; the line stores need no clearing.
module laplacian_3x3_highpass_top #(
  parameter int unsigned MaxWidth  = lap_pkg::MaxWidthDef,
  parameter int unsigned MaxHeight = lap_pkg::MaxHeightDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  lap_pkg::lap_in_t              in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output lap_pkg::lap_out_t             out_data_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [lap_pkg::CfgAddrW-1:0]  cfg_addr_i,
  input  logic [lap_pkg::CfgDataW-1:0]  cfg_data_i
);

  localparam int unsigned AW = $clog2(MaxWidth);

  logic [lap_pkg::CfgDataW-1:0] frame_width_q, frame_height_q;
  logic                         accept, room;
  logic                         rd_en, wr_en;
  logic [AW-1:0]                rd_addr, wr_addr;
  logic [lap_pkg::PixW-1:0]     rd_above, rd_two_above, wr_above, wr_two_above;
  logic [1:0]                   pend_front, pend_core, push_n;
  logic [2:0]                   pend;
  lap_pkg::lap_stage_t          stage;
  lap_pkg::lap_out_t            push0, push1;

  // Configuration registers; writes are always taken.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= lap_pkg::CfgDataW'(lap_pkg::RstFrameWidth);
      frame_height_q <= lap_pkg::CfgDataW'(lap_pkg::RstFrameHeight);
    end else if (cfg_valid_i) begin
      unique case (lap_pkg::lap_cfg_idx_e'(cfg_addr_i))
        lap_pkg::CFG_FRAME_WIDTH:  frame_width_q  <= cfg_data_i;
        lap_pkg::CFG_FRAME_HEIGHT: frame_height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Input handshake.
  assign in_ready_o = room;
  assign accept     = in_valid_i && room;

  lap_front #(
    .MaxWidth  (MaxWidth),
    .MaxHeight (MaxHeight)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .in_data_i      (in_data_i),
    .frame_width_i  (frame_width_q),
    .frame_height_i (frame_height_q),
    .rd_en_o        (rd_en),
    .rd_addr_o      (rd_addr),
    .wr_addr_o      (wr_addr),
    .stage_o        (stage),
    .pend_o         (pend_front)
  );

  // Line stores for the row above and the row two above.
  lap_ram #(
    .Width (lap_pkg::PixW),
    .Depth (MaxWidth)
  ) u_line_above (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (wr_above),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_above)
  );

  lap_ram #(
    .Width (lap_pkg::PixW),
    .Depth (MaxWidth)
  ) u_line_two_above (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (wr_two_above),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_two_above)
  );

  lap_core u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .stage_i        (stage),
    .rd_above_i     (rd_above),
    .rd_two_above_i (rd_two_above),
    .wr_en_o        (wr_en),
    .wr_above_o     (wr_above),
    .wr_two_above_o (wr_two_above),
    .pend_o         (pend_core),
    .push_n_o       (push_n),
    .push0_o        (push0),
    .push1_o        (push1)
  );

  // Results still in the pipeline reserve room in the queue.
  assign pend = 3'(pend_front) + 3'(pend_core);

  lap_outq u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_n_i    (push_n),
    .push0_i     (push0),
    .push1_i     (push1),
    .pend_i      (pend),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

>>> hdl/lap_checker.sv
// Port-level checks of the Laplacian high-pass block, bound to its top level.
// Depends on lap_pkg and assert_macros.svh.
`include "assert_macros.svh"

module lap_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_o,
  input lap_pkg::lap_in_t              in_data_i,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input lap_pkg::lap_out_t             out_data_o,
  input logic                          cfg_valid_i,
  input logic                          cfg_ready_o,
  input logic [lap_pkg::CfgAddrW-1:0]  cfg_addr_i,
  input logic [lap_pkg::CfgDataW-1:0]  cfg_data_i
);

  logic in_acc, cfg_acc;

  assign in_acc  = in_valid_i && in_ready_o;
  assign cfg_acc = cfg_valid_i && cfg_ready_o && (cfg_addr_i == cfg_addr_i)
                   && (cfg_data_i == cfg_data_i) && (in_data_i == in_data_i);

  // A stalled result stays offered and unchanged.
  `LAP_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))

  // A result only appears after an input request was taken.
  `LAP_ASSERT(a_out_after_in, $rose(out_valid_o) |-> $past(in_acc, 3))

  // With an empty result queue the input side is never held off.
  `LAP_ASSERT_NEVER(a_ready_when_empty, !out_valid_o && !in_ready_o)

  // Configuration writes are always taken at once.
  `LAP_ASSERT(a_cfg_taken, cfg_valid_i |-> cfg_acc)

endmodule

bind laplacian_3x3_highpass_top lap_checker u_lap_checker (.*);
